[rtl/core/vct_pkg.sv]
// ----------------------------------------------------------------------------
// vct_pkg
// Shared constants for the vertex clip and viewport transform.
// ----------------------------------------------------------------------------
package vct_pkg;

    // Q16.16 fixed point
    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] Q16_ONE  = 32'sd65536;
    localparam logic signed [31:0] Q16_HALF = 32'sd32768;

    // default viewport size in pixels
    localparam int VIEW_WIDTH_DEF  = 640;
    localparam int VIEW_HEIGHT_DEF = 480;

    // configuration port
    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 3;

    // divider: dividend is |a| shifted up by the fraction bits
    localparam int DIVIDEND_W = 32 + FRAC_BITS;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIVIDEND_W / DIV_STEP;

    // matrix register reset values (identity)
    localparam logic [63:0] ROW_DIAG_LO = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ROW_DIAG_HI = 64'h0001_0000_0000_0000;

endpackage

[rtl/core/vct_stream_if.sv]
// ----------------------------------------------------------------------------
// vct_in_if / vct_out_if
// Valid/ready channels for object-space vertices and screen-space results.
// ----------------------------------------------------------------------------
interface vct_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;

    modport source (output valid, obj_x, obj_y, obj_z, input ready);
    modport sink   (input valid, obj_x, obj_y, obj_z, output ready);
endinterface

interface vct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_out;
    logic signed [31:0] clip_w;
    logic               w_was_zero;
    logic               overflow_seen;

    modport source (output valid, screen_x, screen_y, depth_out, clip_w, w_was_zero,
                    overflow_seen, input ready);
    modport sink   (input valid, screen_x, screen_y, depth_out, clip_w, w_was_zero,
                    overflow_seen, output ready);
endinterface

[rtl/core/vertex_clip_viewport_transform.sv]
// ----------------------------------------------------------------------------
// vertex_clip_viewport_transform
// Q16.16 vertex transform by a 4x4 matrix, perspective divide and viewport map.
// ----------------------------------------------------------------------------
// One vertex is accepted every clock while the output is not stalled. The
// pipeline is a matrix multiply stage, a row sum stage, the divide pipeline
// (DIV_STEP quotient bits per stage, three dividers side by side), a
// viewport add stage, a viewport multiply stage and the output register.
// The whole pipeline holds when the output register is full and not taken.
// The matrix lives in eight 64-bit APB registers at byte address 8*i, two
// Q16.16 entries each, and resets to the identity. The user must write it
// only while the pipeline is empty; the block does not enforce this.
module vertex_clip_viewport_transform #(
    parameter int VIEW_WIDTH  = vct_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = vct_pkg::VIEW_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    vct_in_if.sink                      in_ch,
    vct_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vct_pkg::ADDR_W-1:0]  paddr,
    input  logic [vct_pkg::DATA_W-1:0]  pwdata,
    output logic [vct_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int NS   = vct_pkg::DIV_STAGES;
    localparam int NSTG = NS + 5;
    localparam int P5   = NS + 4;
    localparam int FB   = vct_pkg::FRAC_BITS;

    // half viewport sizes in Q16.16
    localparam logic signed [31:0] HALF_W = 32'(VIEW_WIDTH * vct_pkg::Q16_HALF);
    localparam logic signed [31:0] HALF_H = 32'(VIEW_HEIGHT * vct_pkg::Q16_HALF);

    // ------------------------------------------------------------------------
    // configuration registers
    logic [63:0] mat_reg [vct_pkg::NUM_REGS];
    logic [vct_pkg::REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[vct_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;
    assign prdata  = mat_reg[reg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= vct_pkg::ROW_DIAG_LO;
            mat_reg[1] <= '0;
            mat_reg[2] <= vct_pkg::ROW_DIAG_HI;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= vct_pkg::ROW_DIAG_LO;
            mat_reg[6] <= '0;
            mat_reg[7] <= vct_pkg::ROW_DIAG_HI;
        end
        else if (psel && penable && pwrite && pready)
        begin
            mat_reg[reg_idx] <= pwdata;
        end
    end

    // matrix entry m[r][c]
    logic signed [31:0] m [4][4];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            m[r][0] = $signed(mat_reg[2*r][31:0]);
            m[r][1] = $signed(mat_reg[2*r][63:32]);
            m[r][2] = $signed(mat_reg[2*r+1][31:0]);
            m[r][3] = $signed(mat_reg[2*r+1][63:32]);
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control: everything advances unless the output is stalled
    logic vld_reg [NSTG];
    logic en;

    assign en          = !vld_reg[P5] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_ch.valid;
            for (int i = 1; i < NSTG; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: twelve matrix products, floored and wrapped to 32 bits
    logic signed [31:0] prod_reg [4][3];
    logic signed [31:0] prod_next [4][3];
    logic               povf_reg;
    logic               povf_next;
    logic signed [31:0] mcol_reg [4];

    always_comb
    begin
        logic signed [63:0] p;
        logic signed [31:0] v [3];
        v[0] = in_ch.obj_x;
        v[1] = in_ch.obj_y;
        v[2] = in_ch.obj_z;
        povf_next = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p = m[r][k] * v[k];
                prod_next[r][k] = p[FB+31:FB];
                if (p[63:FB+31] != '0 && p[63:FB+31] != '1)
                begin
                    povf_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            povf_reg <= povf_next;
            for (int r = 0; r < 4; r++)
            begin
                mcol_reg[r] <= m[r][3];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: row sums give the clip-space vector
    logic signed [31:0] clip_reg [4];
    logic               s2ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2] + mcol_reg[r];
            end
            s2ovf_reg <= povf_reg;
        end
    end

    // ------------------------------------------------------------------------
    // divide pipeline: three dividers plus a matching delay line
    logic        w_zero;
    logic [31:0] w_mag;
    logic        w_neg;

    assign w_zero = (clip_reg[3] == '0);
    assign w_neg  = clip_reg[3][31];
    assign w_mag  = w_neg ? 32'(-clip_reg[3]) : clip_reg[3];

    logic signed [31:0] dq   [3];
    logic               dovf [3];

    genvar d;
    generate
        for (d = 0; d < 3; d++) begin : g_div
            logic [31:0] a_mag;
            assign a_mag = clip_reg[d][31] ? 32'(-clip_reg[d]) : clip_reg[d];

            vct_div u_div (
                .clk     (clk),
                .en      (en),
                .num_mag ({a_mag, {FB{1'b0}}}),
                .den_mag (w_mag),
                .neg     (clip_reg[d][31] ^ w_neg),
                .quo     (dq[d]),
                .ovf     (dovf[d])
            );
        end
    endgenerate

    logic signed [31:0] dly_clip_reg [NS][4];
    logic               dly_wz_reg   [NS];
    logic               dly_ovf_reg  [NS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_clip_reg[0] <= clip_reg;
            dly_wz_reg[0]   <= w_zero;
            dly_ovf_reg[0]  <= s2ovf_reg;
            for (int i = 1; i < NS; i++)
            begin
                dly_clip_reg[i] <= dly_clip_reg[i-1];
                dly_wz_reg[i]   <= dly_wz_reg[i-1];
                dly_ovf_reg[i]  <= dly_ovf_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: pick divided or clip values, viewport offsets
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic signed [31:0] s3_depth_reg;
    logic signed [31:0] s3_w_reg;
    logic               s3_wz_reg;
    logic               s3_ovf_reg;

    always_ff @(posedge clk)
    begin
        logic               wz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        wz = dly_wz_reg[NS-1];
        cx = wz ? dly_clip_reg[NS-1][0] : dq[0];
        cy = wz ? dly_clip_reg[NS-1][1] : dq[1];
        if (en)
        begin
            tx_reg       <= cx + vct_pkg::Q16_ONE;
            ty_reg       <= vct_pkg::Q16_ONE - cy;
            s3_depth_reg <= wz ? dly_clip_reg[NS-1][2] : dq[2];
            s3_w_reg     <= dly_clip_reg[NS-1][3];
            s3_wz_reg    <= wz;
            s3_ovf_reg   <= dly_ovf_reg[NS-1] || (!wz && (dovf[0] || dovf[1] || dovf[2]));
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: viewport scale products
    logic signed [63:0] sxp_reg;
    logic signed [63:0] syp_reg;
    logic signed [31:0] s4_depth_reg;
    logic signed [31:0] s4_w_reg;
    logic               s4_wz_reg;
    logic               s4_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxp_reg      <= HALF_W * tx_reg;
            syp_reg      <= HALF_H * ty_reg;
            s4_depth_reg <= s3_depth_reg;
            s4_w_reg     <= s3_w_reg;
            s4_wz_reg    <= s3_wz_reg;
            s4_ovf_reg   <= s3_ovf_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: floor, wrap check, output register
    logic sx_ovf;
    logic sy_ovf;
    assign sx_ovf = (sxp_reg[63:FB+31] != '0) && (sxp_reg[63:FB+31] != '1);
    assign sy_ovf = (syp_reg[63:FB+31] != '0) && (syp_reg[63:FB+31] != '1);

    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] depth_reg;
    logic signed [31:0] w_reg;
    logic               wz_reg;
    logic               ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg    <= sxp_reg[FB+31:FB];
            sy_reg    <= syp_reg[FB+31:FB];
            depth_reg <= s4_depth_reg;
            w_reg     <= s4_w_reg;
            wz_reg    <= s4_wz_reg;
            ovf_reg   <= s4_ovf_reg || sx_ovf || sy_ovf;
        end
    end

    assign out_ch.valid         = vld_reg[P5];
    assign out_ch.screen_x      = sx_reg;
    assign out_ch.screen_y      = sy_reg;
    assign out_ch.depth_out     = depth_reg;
    assign out_ch.clip_w        = w_reg;
    assign out_ch.w_was_zero    = wz_reg;
    assign out_ch.overflow_seen = ovf_reg;

endmodule

[rtl/core/vct_div.sv]
// ----------------------------------------------------------------------------
// vct_div
// Pipelined restoring divider for Q16.16 quotients, DIV_STEP bits per stage,
// with sign restore, 32-bit wrap and an overflow flag.
// ----------------------------------------------------------------------------
module vct_div (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [vct_pkg::DIVIDEND_W-1:0]       num_mag,
    input  logic [31:0]                          den_mag,
    input  logic                                 neg,
    output logic signed [31:0]                   quo,
    output logic                                 ovf
);

    localparam int NW = vct_pkg::DIVIDEND_W;
    localparam int NS = vct_pkg::DIV_STAGES;

    logic [31:0]   rem_reg [NS];
    logic [NW-1:0] num_reg [NS];
    logic [31:0]   den_reg [NS];
    logic          neg_reg [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [31:0]   rem_in;
            logic [NW-1:0] num_in;
            logic [31:0]   den_in;
            logic          neg_in;
            logic [31:0]   rem_next;
            logic [NW-1:0] num_next;

            // stage input: ports for the first stage, previous stage otherwise
            if (s == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = num_mag;
                assign den_in = den_mag;
                assign neg_in = neg;
            end
            else begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign num_in = num_reg[s-1];
                assign den_in = den_reg[s-1];
                assign neg_in = neg_reg[s-1];
            end

            // DIV_STEP restoring steps; quotient bits shift in at the bottom
            always_comb
            begin
                logic [32:0]   trial;
                logic [31:0]   r;
                logic [NW-1:0] n;
                r = rem_in;
                n = num_in;
                for (int k = 0; k < vct_pkg::DIV_STEP; k++)
                begin
                    trial = {r, n[NW-1]};
                    n     = {n[NW-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        r    = 32'(trial - {1'b0, den_in});
                        n[0] = 1'b1;
                    end
                    else
                    begin
                        r = trial[31:0];
                    end
                end
                rem_next = r;
                num_next = n;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    num_reg[s] <= num_next;
                    den_reg[s] <= den_in;
                    neg_reg[s] <= neg_in;
                end
            end
        end
    endgenerate

    // sign restore and wrap check on the final magnitude
    logic [NW-1:0] mag;
    assign mag = num_reg[NS-1];
    assign quo = neg_reg[NS-1] ? $signed(32'(~mag[31:0] + 32'd1)) : $signed(mag[31:0]);
    assign ovf = neg_reg[NS-1] ? (mag > NW'(33'h1_0000_0000 >> 1))
                               : (mag > NW'(32'h7FFF_FFFF));

endmodule

[rtl/core/vct_checker.sv]
// ----------------------------------------------------------------------------
// vct_checker
// Port-level checks on the transform's output channel and backpressure.
// ----------------------------------------------------------------------------
module vct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               w_was_zero,
    input logic signed [31:0] clip_w
);

    // a ready output always frees the input side
    a_ready_follows : assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input not ready while output is taken");

    // a result not taken stays offered
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output result dropped while stalled");

    // the zero flag matches the reported w
    a_wz_match : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (w_was_zero == (clip_w == 32'sd0)))
        else $error("w_was_zero disagrees with clip_w");

    // nothing can come out right after reset
    a_reset_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered just after reset");

endmodule

bind vertex_clip_viewport_transform vct_checker u_vct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .w_was_zero (out_ch.w_was_zero),
    .clip_w     (out_ch.clip_w)
);

[verif/vertex_clip_viewport_transform_test.sv]
// ----------------------------------------------------------------------------
// vertex_clip_viewport_transform_test
// Drives vertices through the transform under several matrices, predicts each
// screen-space result from the loaded matrix and checks it field by field.
// ----------------------------------------------------------------------------
module vertex_clip_viewport_transform_test;

    localparam int VW = 640;
    localparam int VH = 480;
    localparam int LATENCY = vct_pkg::DIV_STAGES + 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_STALL = 60;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] depth;
        logic signed [31:0] w;
        logic               wz;
        logic               ovf;
    } screen_vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [vct_pkg::ADDR_W-1:0] paddr = '0;
    logic [vct_pkg::DATA_W-1:0] pwdata = '0;
    logic [vct_pkg::DATA_W-1:0] prdata;
    logic pready;

    vct_in_if  vin ();
    vct_out_if vout ();

    logic [63:0] matrix_regs [vct_pkg::NUM_REGS];
    screen_vertex_t expected_vertices [$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  allow_gaps = 1'b1;
    bit  hold_output = 1'b0;
    int  hold_cycles = 0;
    bit  stall_request = 1'b0;
    bit  stall_taken = 1'b0;

    vertex_clip_viewport_transform #(.VIEW_WIDTH(VW), .VIEW_HEIGHT(VH)) DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(vin.sink), .out_ch(vout.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        vin.valid = 1'b0;
        vin.obj_x = '0;
        vin.obj_y = '0;
        vin.obj_z = '0;
        vout.ready = 1'b0;
    end

    // q16.16 product floored, low 32 bits kept
    function automatic logic signed [31:0] fx_mul(longint a, longint b, ref bit ovf);
        longint p;
        longint q;
        begin
            p = a * b;
            q = p >>> 16;
            if (q < -64'sd2147483648 || q > 64'sd2147483647)
                ovf = 1'b1;
            return q[31:0];
        end
    endfunction

    // q16.16 quotient truncated toward zero
    function automatic logic signed [31:0] fx_div(longint a, longint w, ref bit ovf);
        longint q;
        begin
            q = (a * 65536) / w;
            if (q < -64'sd2147483648 || q > 64'sd2147483647)
                ovf = 1'b1;
            return q[31:0];
        end
    endfunction

    function automatic logic signed [31:0] mat_entry(int r, int c);
        logic [63:0] word;
        begin
            word = matrix_regs[r * 2 + c / 2];
            return (c % 2) ? word[63:32] : word[31:0];
        end
    endfunction

    function automatic screen_vertex_t transform_vertex(logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z);
        screen_vertex_t res;
        logic signed [31:0] clip [4];
        logic signed [31:0] acc;
        logic signed [31:0] hw;
        logic signed [31:0] hh;
        bit ovf;
        begin
            ovf = 1'b0;
            for (int r = 0; r < 4; r++)
            begin
                acc = fx_mul(mat_entry(r, 0), x, ovf);
                acc = acc + fx_mul(mat_entry(r, 1), y, ovf);
                acc = acc + fx_mul(mat_entry(r, 2), z, ovf);
                acc = acc + mat_entry(r, 3);
                clip[r] = acc;
            end
            res.w = clip[3];
            res.wz = (clip[3] == 0);
            if (!res.wz)
                for (int i = 0; i < 3; i++)
                    clip[i] = fx_div(clip[i], clip[3], ovf);
            hw = fx_mul(longint'(VW) << 16, vct_pkg::Q16_HALF, ovf);
            hh = fx_mul(longint'(VH) << 16, vct_pkg::Q16_HALF, ovf);
            res.sx = fx_mul(hw, 32'(clip[0] + vct_pkg::Q16_ONE), ovf);
            res.sy = fx_mul(hh, 32'(vct_pkg::Q16_ONE - clip[1]), ovf);
            res.depth = clip[2];
            res.ovf = ovf;
            return res;
        end
    endfunction

    // apb write: setup then access, bus left selected for the next write
    task automatic write_matrix_reg(int idx, logic [63:0] value);
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            penable <= 1'b0;
            paddr <= vct_pkg::ADDR_W'(idx * 8);
            pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (idx < vct_pkg::NUM_REGS)
                matrix_regs[idx] = value;
        end
    endtask

    task automatic wait_drained();
        begin
            while (expected_vertices.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic load_matrix(logic [63:0] m [vct_pkg::NUM_REGS]);
        begin
            wait_drained();
            for (int i = 0; i < vct_pkg::NUM_REGS; i++)
                write_matrix_reg(i, m[i]);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    // one vertex transfer, with optional random gap first
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z);
        begin
            if (allow_gaps && $urandom_range(0, 3) == 0)
            begin
                vin.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            vin.valid <= 1'b1;
            vin.obj_x <= x;
            vin.obj_y <= y;
            vin.obj_z <= z;
            @(posedge clk);
            while (!vin.ready)
                @(posedge clk);
            expected_vertices.push_back(transform_vertex(x, y, z));
        end
    endtask

    task automatic end_burst();
        begin
            vin.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'sh0000_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // directed corners under the identity matrix
    task automatic test_identity_corners();
        logic signed [31:0] pts [6] = '{32'sh0, 32'sh1_0000, -32'sh1_0000,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_8000};
        begin
            foreach (pts[i])
                send_vertex(pts[i], pts[(i + 1) % 6], pts[(i + 2) % 6]);
            send_vertex(32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa);
            end_burst();
        end
    endtask

    // w zero, perspective divide, sum wrap and quotient overflow
    task automatic test_special_matrices();
        logic [63:0] m [vct_pkg::NUM_REGS];
        begin
            // w row all zero: divide skipped
            m = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                  64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0};
            load_matrix(m);
            send_vertex(32'sh1_0000, 32'sh2_0000, 32'sh3_0000);
            send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0);
            end_burst();
            // w from z, perspective divide, tiny w overflows quotient
            m = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                  64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0000_0000_0001_0000};
            load_matrix(m);
            send_vertex(32'sh2_0000, -32'sh2_0000, 32'sh4_0000);
            send_vertex(32'sh100_0000, 32'sh1_0000, 32'sh1);
            send_vertex(32'sh1_0000, 32'sh1_0000, -32'sh1);
            send_vertex(32'sh0, 32'sh0, 32'sh0);
            end_burst();
            // extreme entries: all ones and all min
            m = '{64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff,
                  64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                  64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                  64'h0000_0000_0000_0000, 64'h0001_0000_7fff_ffff};
            load_matrix(m);
            send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
            send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
            send_vertex(32'sh1, -32'sh1, 32'sh0);
            send_vertex(32'sh0, 32'sh0, 32'sh0);
            end_burst();
        end
    endtask

    // random vertices through a run of random matrices
    task automatic test_random_stream(int phases, int per_phase);
        logic [63:0] m [vct_pkg::NUM_REGS];
        begin
            for (int p = 0; p < phases; p++)
            begin
                for (int i = 0; i < vct_pkg::NUM_REGS; i++)
                    m[i] = {rand_entry(), rand_entry()};
                if ($urandom_range(0, 2) == 0)
                    m[7] = {32'sh0001_0000, rand_entry()};
                load_matrix(m);
                for (int n = 0; n < per_phase; n++)
                    send_vertex(rand_coord(), rand_coord(), rand_coord());
                end_burst();
            end
        end
    endtask

    // receiver stalls long while sender keeps offering
    task automatic test_backpressure();
        begin
            stall_request = 1'b1;
            for (int n = 0; n < 100; n++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            end_burst();
        end
    endtask

    // output side idling, hold_cycles counts the low cycles left
    always @(posedge clk)
    begin
        if (hold_output)
        begin
            if (hold_cycles > 1)
            begin
                vout.ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
            begin
                vout.ready <= rst_n;
                hold_output <= 1'b0;
            end
        end
        else if (stall_request && !stall_taken)
        begin
            vout.ready <= 1'b0;
            hold_cycles <= LONG_STALL;
            hold_output <= 1'b1;
            stall_taken <= 1'b1;
        end
        else if (allow_gaps && rst_n && $urandom_range(0, 7) == 0)
        begin
            vout.ready <= 1'b0;
            hold_cycles <= $urandom_range(1, 8);
            hold_output <= 1'b1;
        end
        else
            vout.ready <= rst_n;
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && vout.valid && vout.ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("unexpected transfer: screen_x %h", vout.screen_x);
                mismatch_count++;
            end
            else
            begin
                screen_vertex_t e;
                e = expected_vertices.pop_front();
                if (vout.screen_x !== e.sx)
                begin
                    $error("screen_x expected %h actual %h", e.sx, vout.screen_x);
                    mismatch_count++;
                end
                if (vout.screen_y !== e.sy)
                begin
                    $error("screen_y expected %h actual %h", e.sy, vout.screen_y);
                    mismatch_count++;
                end
                if (vout.depth_out !== e.depth)
                begin
                    $error("depth_out expected %h actual %h", e.depth, vout.depth_out);
                    mismatch_count++;
                end
                if (vout.clip_w !== e.w)
                begin
                    $error("clip_w expected %h actual %h", e.w, vout.clip_w);
                    mismatch_count++;
                end
                if (vout.w_was_zero !== e.wz)
                begin
                    $error("w_was_zero expected %b actual %b", e.wz, vout.w_was_zero);
                    mismatch_count++;
                end
                if (vout.overflow_seen !== e.ovf)
                begin
                    $error("overflow_seen expected %b actual %b", e.ovf,
                           vout.overflow_seen);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((vin.valid && vin.ready) || (vout.valid && vout.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        matrix_regs = '{vct_pkg::ROW_DIAG_LO, 64'h0, vct_pkg::ROW_DIAG_HI, 64'h0,
                        64'h0, vct_pkg::ROW_DIAG_LO, 64'h0, vct_pkg::ROW_DIAG_HI};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_corners();
        test_special_matrices();
        test_backpressure();
        test_random_stream(12, 120);
        allow_gaps = 1'b0;
        test_random_stream(2, 150);
        wait_drained();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
